// ----- hdl/spq_pkg.sv -----
// Package for the sorted priority queue: sizes, operation and status codes,
// controller states and the command struct. No dependencies.
`default_nettype none

package spq_pkg;

    // Number of cells in the sorted chain.
    localparam int CAPACITY   = 16;
    // Width of the data word held in a cell.
    localparam int DATA_WIDTH = 32;

    // Widths of the ports and of the stored fields.
    localparam int PORT_DATA_W = 32;
    localparam int PRIO_W      = 32;
    localparam int COUNT_W     = 5;
    localparam int STORE_W     = (DATA_WIDTH < PORT_DATA_W) ? DATA_WIDTH : PORT_DATA_W;
    localparam int FILL_W      = $clog2(CAPACITY + 1);

    // Request codes; the fourth code is unused and answers not found.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2
    } t_spq_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_spq_status;

    // Controller states.
    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } t_spq_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the request and the per-cell compare flags
        logic commit;   // update the cells and load the result registers
    } t_spq_cmd;

endpackage

`default_nettype wire

// ----- hdl/spq_ctrl.sv -----
// Controller for the sorted priority queue: request handshake, the
// two-state sequencer and the result valid flag. Depends on spq_pkg.
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    input  wire logic     i_res_ready,
    output logic          o_req_ready,
    output logic          o_res_valid,
    output t_spq_cmd      o_cmd
);

    t_spq_state r_state;
    t_spq_state n_state;
    logic       r_res_valid;
    logic       n_res_valid;

    // State and result flag registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    // Next state and commands. A result may only be loaded when the result
    // register is empty or is being emptied in this cycle.
    always_comb begin
        n_state       = r_state;
        n_res_valid   = r_res_valid;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        o_req_ready   = 1'b0;

        if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_APPLY;
                end
            end
            S_APPLY: begin
                if (!r_res_valid || i_res_ready) begin
                    o_cmd.commit = 1'b1;
                    n_res_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res_valid = r_res_valid;

endmodule

`default_nettype wire

// ----- hdl/spq_datapath.sv -----
// Datapath for the sorted priority queue: the chain of sorted cells, the
// per-cell compare flags, the fill count and the result registers.
// Depends on spq_pkg.
`default_nettype none

module spq_datapath
    import spq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_spq_cmd                 i_cmd,
    input  wire logic [1:0]               i_req_type,
    input  wire logic [PORT_DATA_W-1:0]   i_data_in,
    input  wire logic signed [PRIO_W-1:0] i_prio_in,
    output logic [1:0]                    o_status,
    output logic [PORT_DATA_W-1:0]        o_data_out,
    output logic [COUNT_W-1:0]            o_entry_count
);

    // Cell contents, kept in ascending priority order from cell zero.
    logic        [STORE_W-1:0] r_cell_data [CAPACITY];
    logic signed [PRIO_W-1:0]  r_cell_prio [CAPACITY];
    logic        [FILL_W-1:0]  r_fill;
    logic        [FILL_W-1:0]  n_fill;

    // Latched request.
    logic [1:0]                r_op;
    logic [STORE_W-1:0]        r_din;
    logic signed [PRIO_W-1:0]  r_pin;

    // Per-cell flags, computed at acceptance and registered.
    logic [CAPACITY-1:0] c_place, c_ge, c_eq, c_first, c_hit;
    logic [CAPACITY-1:0] r_place, r_ge, r_first, r_hit;
    logic [STORE_W-1:0]  c_din;

    // Result registers.
    logic [1:0]             r_status;
    logic [STORE_W-1:0]     r_dout;
    logic [COUNT_W-1:0]     r_count;

    // Decisions taken in the commit cycle.
    logic               w_full;
    logic               w_found;
    logic               w_hit;
    logic               w_do_ins;
    logic               w_do_rem;
    logic [STORE_W-1:0] w_sel_data;
    logic [1:0]         w_status;

    assign c_din = i_data_in[STORE_W-1:0];

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++) begin : g_cell
            logic               w_valid;
            logic               w_prev_place;
            logic [STORE_W-1:0] w_prev_data;
            logic [PRIO_W-1:0]  w_prev_prio;
            logic [STORE_W-1:0] w_next_data;
            logic [PRIO_W-1:0]  w_next_prio;
            logic               w_has_next;
            logic [STORE_W-1:0] n_data;
            logic [PRIO_W-1:0]  n_prio;

            // A cell holds an entry when it lies below the fill count.
            assign w_valid = (FILL_W'(k) < r_fill);

            // Compare flags against the incoming request. Since the chain is
            // sorted, equal priorities form one contiguous run.
            assign c_place[k] = !(w_valid && (r_cell_prio[k] <= i_prio_in));
            assign c_ge[k]    = w_valid && (r_cell_prio[k] >= i_prio_in);
            assign c_eq[k]    = w_valid && (r_cell_prio[k] == i_prio_in);
            assign c_hit[k]   = c_eq[k] && (r_cell_data[k] == c_din);

            // Neighbor taps for shifting.
            if (k == 0) begin : g_head
                assign c_first[k]   = c_eq[k];
                assign w_prev_place = 1'b0;
                assign w_prev_data  = r_cell_data[k];
                assign w_prev_prio  = r_cell_prio[k];
            end else begin : g_body
                assign c_first[k]   = c_eq[k] && !c_eq[k-1];
                assign w_prev_place = r_place[k-1];
                assign w_prev_data  = r_cell_data[k-1];
                assign w_prev_prio  = r_cell_prio[k-1];
            end

            if (k == CAPACITY - 1) begin : g_tail
                assign w_has_next  = 1'b0;
                assign w_next_data = r_cell_data[k];
                assign w_next_prio = r_cell_prio[k];
            end else begin : g_inner
                assign w_has_next  = 1'b1;
                assign w_next_data = r_cell_data[k+1];
                assign w_next_prio = r_cell_prio[k+1];
            end

            // Insert shifts the cells at and after the insertion point one
            // place back; remove pulls the cells after the match forward.
            always_comb begin
                n_data = r_cell_data[k];
                n_prio = r_cell_prio[k];
                if (w_do_ins) begin
                    if (w_prev_place) begin
                        n_data = w_prev_data;
                        n_prio = w_prev_prio;
                    end else if (r_place[k]) begin
                        n_data = r_din;
                        n_prio = r_pin;
                    end
                end else if (w_do_rem) begin
                    if (r_ge[k] && w_has_next) begin
                        n_data = w_next_data;
                        n_prio = w_next_prio;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.commit) begin
                    r_cell_data[k] <= n_data;
                    r_cell_prio[k] <= n_prio;
                end
            end
        end
    endgenerate

    // Latch the request and its compare flags on transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_req_type;
            r_din   <= c_din;
            r_pin   <= i_prio_in;
            r_place <= c_place;
            r_ge    <= c_ge;
            r_first <= c_first;
            r_hit   <= c_hit;
        end
    end

    // Data of the first matching cell, selected by its one-hot flag.
    always_comb begin
        w_sel_data = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            w_sel_data = w_sel_data | (r_cell_data[j] & {STORE_W{r_first[j]}});
        end
    end

    assign w_full   = (r_fill == FILL_W'(CAPACITY));
    assign w_found  = |r_first;
    assign w_hit    = |r_hit;
    assign w_do_ins = (r_op == OP_INSERT) && !w_full;
    assign w_do_rem = (r_op == OP_REMOVE) && w_found;

    // Status and new fill count of the operation.
    always_comb begin
        w_status = ST_NOT_FOUND;
        n_fill   = r_fill;
        case (t_spq_op'(r_op))
            OP_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_status = ST_OK;
                    n_fill   = r_fill + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (r_fill == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_found) begin
                    w_status = ST_OK;
                    n_fill   = r_fill - 1'b1;
                end else begin
                    w_status = ST_NOT_FOUND;
                end
            end
            OP_SEARCH: begin
                w_status = w_hit ? ST_OK : ST_NOT_FOUND;
            end
            default: begin
                w_status = ST_NOT_FOUND;
            end
        endcase
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.commit) begin
            r_fill <= n_fill;
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= w_status;
            r_dout   <= w_do_rem ? w_sel_data : '0;
            r_count  <= COUNT_W'(n_fill);
        end
    end

    assign o_status      = r_status;
    assign o_data_out    = PORT_DATA_W'(r_dout);
    assign o_entry_count = r_count;

endmodule

`default_nettype wire

// ----- hdl/sorted_priority_queue_top.sv -----
// Top level of the sorted priority queue: joins the controller and the
// datapath. Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// The queue holds up to CAPACITY entries in a chain of cells sorted by signed
// priority, front first; equal priorities keep arrival order. Each operation
// (insert, remove by priority, search by data and priority) runs as follows:
// on the request transfer every cell compares itself with the request and the
// flags are registered; then, once the result register is free or is being
// emptied, the chain shifts in one step and the result register is loaded.
// One operation is in work at a time, so no new request is taken until the
// current one commits; a finished result may wait in its register while the
// next request is accepted. In the datapath, reset only clears the fill count.
`default_nettype none

module sorted_priority_queue_top
    import spq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [1:0]               i_req_type,
    input  wire logic [PORT_DATA_W-1:0]   i_data_in,
    input  wire logic signed [PRIO_W-1:0] i_prio_in,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [1:0]                    o_status,
    output logic [PORT_DATA_W-1:0]        o_data_out,
    output logic [COUNT_W-1:0]            o_entry_count
);

    t_spq_cmd w_cmd;

    // Sequencer and handshakes.
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_res_ready (i_ready),
        .o_req_ready (o_ready),
        .o_res_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    // Sorted cells and result registers.
    spq_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_req_type    (i_req_type),
        .i_data_in     (i_data_in),
        .i_prio_in     (i_prio_in),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire

// ----- tb/sorted_priority_queue_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue_top: insert, remove by priority
// and search requests are predicted on a software copy of the sorted queue. Depends on spq_pkg.

module sorted_priority_queue_top_tb
    import spq_pkg::*;
;

    // The fourth request code has no operation behind it.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [PORT_DATA_W-1:0] DATA_KEEP = {PORT_DATA_W{1'b1}} >> (PORT_DATA_W - STORE_W);
    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};
    localparam logic signed [PRIO_W-1:0] PRIO_MAX = {1'b0, {(PRIO_W-1){1'b1}}};
    localparam int RANDOM_REQUESTS = 500;
    localparam int CALM_TAIL = 60;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic [1:0]                 op;
        logic [PORT_DATA_W-1:0]     data;
        logic signed [PRIO_W-1:0]   prio;
        int                         gap;
    } t_queue_request;

    typedef struct {
        t_spq_status                status;
        logic [PORT_DATA_W-1:0]     data;
        logic [COUNT_W-1:0]         count;
    } t_queue_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [1:0]                 i_req_type = OP_INSERT;
    logic [PORT_DATA_W-1:0]     i_data_in = '0;
    logic signed [PRIO_W-1:0]   i_prio_in = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [1:0]                 o_status;
    logic [PORT_DATA_W-1:0]     o_data_out;
    logic [COUNT_W-1:0]         o_entry_count;

    t_queue_request             pending_requests[$];
    t_queue_result              expected_results[$];
    t_queue_request             next_request;
    t_queue_result              oldest_result;
    int                         failures = 0;
    int                         cycle_count = 0;
    int                         stall_left = 0;

    // Software copy of the sorted queue, front at index zero.
    logic [PORT_DATA_W-1:0]     held_data[CAPACITY];
    logic signed [PRIO_W-1:0]   held_prio[CAPACITY];
    int                         held_count = 0;

    sorted_priority_queue_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_data_in     (i_data_in),
        .i_prio_in     (i_prio_in),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_entry_count (o_entry_count)
    );

    // Applies one request to the software queue and returns the result it gives.
    function automatic t_queue_result predict_queue_op(input logic [1:0] op,
                                                       input logic [PORT_DATA_W-1:0] data,
                                                       input logic signed [PRIO_W-1:0] prio);
        t_queue_result r;
        logic [PORT_DATA_W-1:0] d;
        int pos;
        d = data & DATA_KEEP;
        r.status = ST_NOT_FOUND;
        r.data = '0;
        case (op)
            OP_INSERT: begin
                if (held_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // Land behind every entry of lower or equal priority.
                    pos = 0;
                    while (pos < held_count && held_prio[pos] <= prio) pos++;
                    for (int k = held_count; k > pos; k--) begin
                        held_data[k] = held_data[k-1];
                        held_prio[k] = held_prio[k-1];
                    end
                    held_data[pos] = d;
                    held_prio[pos] = prio;
                    held_count++;
                    r.status = ST_OK;
                end
            end
            OP_REMOVE: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = 0;
                    while (pos < held_count && held_prio[pos] != prio) pos++;
                    if (pos < held_count) begin
                        r.data = held_data[pos];
                        for (int k = pos; k + 1 < held_count; k++) begin
                            held_data[k] = held_data[k+1];
                            held_prio[k] = held_prio[k+1];
                        end
                        held_count--;
                        r.status = ST_OK;
                    end
                end
            end
            OP_SEARCH: begin
                for (int k = 0; k < held_count; k++) begin
                    if (held_prio[k] == prio && held_data[k] == d) r.status = ST_OK;
                end
            end
            default: r.status = ST_NOT_FOUND;
        endcase
        r.count = COUNT_W'(held_count);
        return r;
    endfunction

    function automatic void add_request(input logic [1:0] op,
                                        input logic [PORT_DATA_W-1:0] data,
                                        input logic signed [PRIO_W-1:0] prio,
                                        input int gap);
        t_queue_request req;
        req.op = op;
        req.data = data;
        req.prio = prio;
        req.gap = gap;
        pending_requests.push_back(req);
    endfunction

    // Priorities and data words drawn from small pools so that removes and searches hit.
    function automatic logic signed [PRIO_W-1:0] pick_prio();
        logic signed [PRIO_W-1:0] pool[8];
        pool = '{PRIO_MIN, -32'sd1, 32'sd0, 32'sd1, 32'sd2, 32'sd100, PRIO_MAX, -32'sd7};
        if ($urandom_range(0, 4) == 0) return $urandom;
        return pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [PORT_DATA_W-1:0] pick_data();
        if ($urandom_range(0, 2) == 0) return $urandom;
        return PORT_DATA_W'($urandom_range(0, 5));
    endfunction

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Request side: transfers the queued requests, with random idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_results.push_back(predict_queue_op(i_req_type, i_data_in, i_prio_in));
            end
            if (!i_valid || o_ready) begin
                if (pending_requests.size() > 0 && pending_requests[0].gap > 0) begin
                    pending_requests[0].gap = pending_requests[0].gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    next_request = pending_requests.pop_front();
                    i_req_type <= next_request.op;
                    i_data_in <= next_request.data;
                    i_prio_in <= next_request.prio;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: random stall bursts, and every transfer checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    failures++;
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (o_status !== oldest_result.status) begin
                        $error("status: expected %0d, got %0d", oldest_result.status, o_status);
                        failures++;
                    end
                    if (o_data_out !== oldest_result.data) begin
                        $error("data_out: expected 0x%08h, got 0x%08h",
                               oldest_result.data, o_data_out);
                        failures++;
                    end
                    if (o_entry_count !== oldest_result.count) begin
                        $error("entry_count: expected %0d, got %0d",
                               oldest_result.count, o_entry_count);
                        failures++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready <= 1'b0;
            end else if (pending_requests.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(0, 12);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[sorted_priority_queue_top] ERROR");
            $finish;
        end
    end

    initial begin
        int insert_weight;
        int roll;
        int gap;
        logic [1:0] op;
        logic idle_on;

        // Empty queue: remove, search and the unused code.
        add_request(OP_REMOVE, 32'h0, 32'sd0, 0);
        add_request(OP_SEARCH, 32'h0, 32'sd0, 0);
        add_request(OP_UNUSED, 32'hFFFF_FFFF, PRIO_MAX, 0);
        // Priority extremes, and two entries of equal priority that must keep arrival order.
        add_request(OP_INSERT, 32'h0, PRIO_MIN, 0);
        add_request(OP_INSERT, 32'hFFFF_FFFF, PRIO_MAX, 0);
        add_request(OP_INSERT, 32'hAAAA_5555, 32'sd5, 0);
        add_request(OP_INSERT, 32'h5555_AAAA, 32'sd5, 0);
        add_request(OP_SEARCH, 32'hAAAA_5555, 32'sd5, 0);
        add_request(OP_SEARCH, 32'hAAAA_5555, 32'sd6, 0);
        add_request(OP_SEARCH, 32'h0, PRIO_MIN, 0);
        add_request(OP_REMOVE, 32'h0, 32'sd7, 0);
        add_request(OP_REMOVE, 32'h0, 32'sd5, 0);
        add_request(OP_REMOVE, 32'h0, PRIO_MAX, 0);
        // Two entries are left; fill to capacity, then push once more against a full queue.
        for (int k = 0; k < CAPACITY - 2; k++) begin
            add_request(OP_INSERT, $urandom, $urandom_range(0, 8), 0);
        end
        add_request(OP_INSERT, 32'h1234_5678, 32'sd3, 0);
        add_request(OP_UNUSED, 32'h0, 32'sd0, 0);
        add_request(OP_REMOVE, 32'h0, PRIO_MIN, 0);

        // Random part in stretches of 50 that alternate between a heavy and a light share of inserts.
        idle_on = 1'b1;
        insert_weight = 70;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i % 50 == 0) begin
                insert_weight = ((i / 50) % 2 == 0) ? 70 : 25;
                idle_on = ($urandom_range(0, 2) != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 4) op = OP_UNUSED;
            else if (roll < 4 + insert_weight) op = OP_INSERT;
            else if (roll < 84) op = OP_SEARCH;
            else op = OP_REMOVE;
            gap = 0;
            if (idle_on && i < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 13);
            end
            add_request(op, pick_data(), pick_prio(), gap);
        end

        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to transfer, every result to arrive, then drain.
        @(posedge i_clk);
        while (pending_requests.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (failures == 0) begin
            $display("[sorted_priority_queue_top] OK");
        end else begin
            $display("[sorted_priority_queue_top] ERROR");
        end
        $finish;
    end

endmodule
